@@ hdl/text_console_cell_writer_assert.svh @@
// ----------------------------------------------------------------------------
// Text console cell writer assertion macros
// Concurrent check macros sampled on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define TCCW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCCW_ASSERT_SAME(lbl, ante, cons, msg)
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/tccw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console cell writer package
// Shared types, command codes and the character mapping function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 40;
    localparam int ROWS_DEF    = 24;

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CTRL_END = 8'h20;
    localparam logic [7:0] CHAR_UPPER_END = 8'h60;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;
    localparam logic [7:0] REVERSE_BIT = 8'h80;

    // Command codes
    typedef enum logic [2:0] {
        ACT_PUT_CUR = 3'd0,
        ACT_MOVE    = 3'd1,
        ACT_PUT_AT  = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_REVERSE = 3'd4,
        ACT_BLANK   = 3'd5,
        ACT_READ    = 3'd6
    } action_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_READ,
        ST_DONE
    } state_t;

    // Map a character byte to a screen code
    function automatic logic [7:0] map_char(input logic [7:0] c, input logic rev);
        logic [7:0] sc;
        begin
            if (c < CHAR_CTRL_END)
            begin
                sc = c + CTRL_OFFSET;
            end
            else if (c < CHAR_UPPER_END)
            begin
                sc = c - CHAR_SPACE;
            end
            else
            begin
                sc = c;
            end
            map_char = rev ? (sc | REVERSE_BIT) : sc;
        end
    endfunction

endpackage

@@ hdl/text_console_cell_writer.sv @@
// Results: put, move, set reverse and unused codes show a result in the cycle after the transfer;
// read cell passes the read and done states; blank run and clear screen pass run or clear, then done.
// Throughput: one command at a time; put, move, set reverse and unused codes sustain one per cycle
// while m_tready stays high, as the cell memory takes one write per cycle and a run or clear
// writes one cell per cycle. Reset: cursor and reverse flag clear at once; a sweep of every
// cell then zeroes the cell memory, and no command is taken until it ends.
// ----------------------------------------------------------------------------
// Text console cell writer
// Character cell console: maps and stores characters, moves the cursor, reads cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_console_cell_writer_assert.svh"

module text_console_cell_writer import tccw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_x[7:0], pos_y[15:8], char_code[23:16], reverse_on[24], run_length[32:25], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cursor_col[7:0], cursor_row[15:8], old_reverse[16], cell_code[24:17], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    state_t state_reg, state_next;

    logic [7:0]        col_reg, col_next;
    logic [7:0]        row_reg, row_next;
    logic              rev_reg, rev_next;
    logic              old_rev_reg, old_rev_next;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        count_reg, count_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_cmd_reg, clr_cmd_next;
    logic              rd_hit_reg, rd_hit_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_col_reg, out_row_reg, out_code_reg;
    logic              out_old_reg;

    logic              out_load;
    logic [7:0]        out_col, out_row, out_code;
    logic              out_old;
    logic              out_free;

    action_t           act;
    logic [7:0]        pos_x, pos_y, char_code, run_length;
    logic              reverse_on;
    logic              accept;

    logic [7:0]        base_col, base_row;
    logic              on_screen;
    logic [15:0]       cell_prod;
    logic [ADDR_W-1:0] cell_addr;
    logic [7:0]        col_inc;
    logic [7:0]        adv_col, adv_row;
    logic [7:0]        put_char, put_code;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // Unpack the input transfer
    assign act        = action_t'(s_tuser[2:0]);
    assign pos_x      = s_tdata[7:0];
    assign pos_y      = s_tdata[15:8];
    assign char_code  = s_tdata[23:16];
    assign reverse_on = s_tdata[24];
    assign run_length = s_tdata[32:25];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Select the position that the cell access works on
    always_comb
    begin
        base_col = col_reg;
        base_row = row_reg;
        if (state_reg == ST_IDLE)
        begin
            case (act)
                ACT_PUT_AT, ACT_READ:
                begin
                    base_col = pos_x;
                    base_row = pos_y;
                end
                default:
                begin
                    base_col = col_reg;
                    base_row = row_reg;
                end
            endcase
        end
    end

    // Cell address and on-screen test
    assign on_screen = (base_row < 8'(ROWS)) && (base_col < 8'(COLUMNS));
    assign cell_prod = 16'(base_row) * 16'(COLUMNS) + 16'(base_col);
    assign cell_addr = cell_prod[ADDR_W-1:0];

    // Advance the cursor past one character
    assign col_inc = base_col + 8'd1;
    always_comb
    begin
        if (col_inc >= 8'(COLUMNS))
        begin
            adv_col = 8'd0;
            adv_row = ((9'(base_row) + 9'd1) < 9'(ROWS)) ? (base_row + 8'd1) : base_row;
        end
        else
        begin
            adv_col = col_inc;
            adv_row = base_row;
        end
    end

    // Map the character being put
    assign put_char = (state_reg == ST_RUN) ? CHAR_SPACE : char_code;
    assign put_code = map_char(put_char, rev_reg);

    // Next state, cell writes and result selection
    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        rev_next      = rev_reg;
        old_rev_next  = old_rev_reg;
        code_next     = code_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        clr_cmd_next  = clr_cmd_reg;
        rd_hit_next   = rd_hit_reg;
        ram_we        = 1'b0;
        ram_waddr     = cell_addr;
        ram_wdata     = put_code;
        out_load      = 1'b0;
        out_col       = col_reg;
        out_row       = row_reg;
        out_old       = rev_reg;
        out_code      = 8'd0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = 8'd0;
                if (clr_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next   = clr_cmd_reg ? ST_DONE : ST_IDLE;
                    clr_cmd_next = 1'b0;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    old_rev_next = rev_reg;
                    code_next    = 8'd0;
                    case (act)
                        ACT_PUT_CUR, ACT_PUT_AT:
                        begin
                            ram_we   = on_screen;
                            col_next = adv_col;
                            row_next = adv_row;
                            out_load = 1'b1;
                            out_col  = adv_col;
                            out_row  = adv_row;
                            out_code = on_screen ? put_code : 8'd0;
                        end
                        ACT_MOVE:
                        begin
                            col_next = pos_x;
                            row_next = pos_y;
                            out_load = 1'b1;
                            out_col  = pos_x;
                            out_row  = pos_y;
                        end
                        ACT_CLEAR:
                        begin
                            col_next      = 8'd0;
                            row_next      = 8'd0;
                            clr_addr_next = '0;
                            clr_cmd_next  = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        ACT_REVERSE:
                        begin
                            rev_next = reverse_on;
                            out_load = 1'b1;
                        end
                        ACT_BLANK:
                        begin
                            col_next   = pos_x;
                            row_next   = pos_y;
                            count_next = run_length;
                            state_next = ST_RUN;
                        end
                        ACT_READ:
                        begin
                            rd_hit_next = on_screen;
                            state_next  = ST_READ;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                if (count_reg != 8'd0)
                begin
                    ram_we     = on_screen;
                    col_next   = adv_col;
                    row_next   = adv_row;
                    count_next = count_reg - 8'd1;
                    if (on_screen)
                    begin
                        code_next = put_code;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_READ:
            begin
                code_next  = rd_hit_reg ? ram_rdata : 8'd0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                out_old  = old_rev_reg;
                out_code = code_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    // Hold the controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold cursor, flags and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            rev_reg       <= 1'b0;
            count_reg     <= 8'd0;
            clr_addr_reg  <= '0;
            clr_cmd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            rev_reg       <= rev_next;
            count_reg     <= count_next;
            clr_addr_reg  <= clr_addr_next;
            clr_cmd_reg   <= clr_cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold command payload and the result word
    always_ff @(posedge clk)
    begin
        old_rev_reg <= old_rev_next;
        code_reg    <= code_next;
        rd_hit_reg  <= rd_hit_next;
        if (out_load)
        begin
            out_col_reg  <= out_col;
            out_row_reg  <= out_row;
            out_old_reg  <= out_old;
            out_code_reg <= out_code;
        end
    end

    // Cell memory
    tccw_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cell_addr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_code_reg, out_old_reg, out_row_reg, out_col_reg};

    // Checks
    `TCCW_ASSERT_SAME(a_clear_writes_zero, state_reg == ST_CLEAR,
        ram_we && (ram_wdata == 8'd0), "clear sweep must write zero cells")
    `TCCW_ASSERT_NEXT(a_clear_homes_cursor,
        (state_reg == ST_CLEAR) && clr_cmd_reg && (clr_addr_reg == ADDR_W'(CELLS - 1)),
        (col_reg == 8'd0) && (row_reg == 8'd0) && (state_reg == ST_DONE),
        "clear command must end with cursor home")
    `TCCW_ASSERT_NEXT(a_run_counts_down, (state_reg == ST_RUN) && (count_reg != 8'd0),
        count_reg == ($past(count_reg) - 8'd1), "blank run count must step down by one")
    `TCCW_ASSERT_SAME(a_no_result_overrun, out_load, out_free,
        "result loaded while previous result still held")
    `TCCW_ASSERT_SAME(a_no_write_during_read, state_reg == ST_READ, !ram_we,
        "cell write during a read")

endmodule

@@ hdl/tccw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 960,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
